>>> hdl/assert_macros.svh
// Assertion helper macros, included by the top-level RTL file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/att_pkg.sv
// Shared constants and types for the ANSI text terminal.
// No dependencies.
package att_pkg;

	typedef logic [1:0] esc_state_t;

	// Escape parser states, also reported as parse_state
	localparam esc_state_t ESC_NORMAL = 2'd0;
	localparam esc_state_t ESC_SEEN   = 2'd1;
	localparam esc_state_t ESC_CSI    = 2'd2;

	// Control and punctuation bytes
	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_DEL    = 8'h7F;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_BLANK  = 8'h20;

	// CSI final bytes
	localparam logic [7:0] CMD_UP    = 8'h41;
	localparam logic [7:0] CMD_DOWN  = 8'h42;
	localparam logic [7:0] CMD_RIGHT = 8'h43;
	localparam logic [7:0] CMD_LEFT  = 8'h44;
	localparam logic [7:0] CMD_HOME  = 8'h48;
	localparam logic [7:0] CMD_ED    = 8'h4A;
	localparam logic [7:0] CMD_EL    = 8'h4B;
	localparam logic [7:0] CMD_HVP   = 8'h66;

	localparam logic [15:0] ARG_MAX = 16'hFFFF;

	typedef logic [15:0] csi_arg_t;

endpackage

>>> hdl/att_if.sv
// Handshake interfaces for the terminal's input and result channels.
// No dependencies.
interface att_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] byte_in;
	logic [4:0] read_row;
	logic [5:0] read_col;

	modport source(output valid, mode, byte_in, read_row, read_col, input ready);
	modport sink(input valid, mode, byte_in, read_row, read_col, output ready);
endinterface

interface att_out_if;
	logic       valid;
	logic       ready;
	logic [4:0] cursor_row_out;
	logic [5:0] cursor_col_out;
	logic [7:0] cell_char;
	logic [1:0] parse_state;

	modport source(output valid, cursor_row_out, cursor_col_out, cell_char, parse_state,
		input ready);
	modport sink(input valid, cursor_row_out, cursor_col_out, cell_char, parse_state,
		output ready);
endinterface

>>> hdl/att_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module att_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1200,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/ansi_text_terminal_top.sv
// ANSI text terminal: character grid in one RAM, cursor and CSI parser in flops.
// An item is accepted in the idle state; the put state then loads the result register once
// the result channel is free, and no new item is taken meanwhile. A clear walks its cells
// one per cycle; a scroll copies (GRID_ROWS-1)*GRID_COLS cells, then blanks GRID_COLS,
// one RAM write a cycle. Reset (arst_n low) clears control state, then a pass over all
// GRID_ROWS*GRID_COLS cells fills the grid with spaces before the first item is taken.
module ansi_text_terminal_top #(
	parameter int GRID_ROWS = 20,
	parameter int GRID_COLS = 60
) (
	input  logic     clk,
	input  logic     arst_n,
	att_in_if.sink   byte_ch,
	att_out_if.source result_ch
);
	import att_pkg::*;
	`include "assert_macros.svh"

	localparam int CELLS = GRID_ROWS * GRID_COLS;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int RW    = $clog2(GRID_ROWS);
	localparam int CW    = $clog2(GRID_COLS);

	localparam logic [RW-1:0] LAST_ROW    = RW'(GRID_ROWS - 1);
	localparam logic [CW-1:0] LAST_COL    = CW'(GRID_COLS - 1);
	localparam logic [AW-1:0] ROW_STEP    = AW'(GRID_COLS);
	localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
	localparam logic [AW-1:0] COPY_LAST   = AW'((GRID_ROWS - 1) * GRID_COLS - 1);
	localparam logic [AW-1:0] BOTTOM_BASE = AW'((GRID_ROWS - 1) * GRID_COLS);

	// Sequencer states
	localparam logic [2:0] ST_FILL   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_SCROLL = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_PUT    = 3'd4;

	logic [2:0]    state_q;
	logic [RW-1:0] cur_row_q;
	logic [CW-1:0] cur_col_q;
	esc_state_t    esc_q;
	csi_arg_t      first_q, second_q;
	logic          have_first_q, have_second_q;

	logic [AW-1:0] fill_q, fill_end_q;
	logic          fill_put_q;
	logic [AW-1:0] scr_q;
	logic          cp_valid_s1;
	logic [AW-1:0] cp_addr_s1;
	logic          cell_hit_q;

	logic          out_valid_q;
	logic [4:0]    out_row_q;
	logic [5:0]    out_col_q;
	logic [7:0]    out_cell_q;
	esc_state_t    out_esc_q;

	// RAM ports
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata;

	att_ram #(.WIDTH(8), .DEPTH(CELLS)) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	logic accept, put_load;
	assign byte_ch.ready = (state_q == ST_IDLE);
	assign accept        = byte_ch.valid && byte_ch.ready;
	assign put_load      = (state_q == ST_PUT) && (!out_valid_q || result_ch.ready);

	// Addresses around the cursor and the read request
	logic [AW-1:0] row_base, cur_addr, row_end, rd_req_addr;
	logic          rd_hit;
	assign row_base    = AW'(AW'(cur_row_q) * ROW_STEP);
	assign cur_addr    = row_base + AW'(cur_col_q);
	assign row_end     = row_base + AW'(GRID_COLS - 1);
	assign rd_hit      = (int'(byte_ch.read_row) < GRID_ROWS) &&
		(int'(byte_ch.read_col) < GRID_COLS);
	assign rd_req_addr = AW'(AW'(byte_ch.read_row) * ROW_STEP) + AW'(byte_ch.read_col);

	// CSI argument math
	csi_arg_t    a1, a2, n1, n2, acc, pushed;
	logic [19:0] acc_x10;
	logic [16:0] row_sum, col_sum;
	logic [RW-1:0] row_home, row_up, row_dn;
	logic [CW-1:0] col_home, col_rt, col_lf;

	always_comb begin
		a1      = have_first_q ? first_q : '0;
		a2      = have_second_q ? second_q : '0;
		n1      = (a1 == '0) ? 16'd1 : a1;
		n2      = (a2 == '0) ? 16'd1 : a2;
		acc     = have_second_q ? second_q : first_q;
		acc_x10 = 20'(acc) * 20'd10 + 20'(4'(byte_ch.byte_in - CH_ZERO));
		pushed  = (acc_x10 > 20'(ARG_MAX)) ? ARG_MAX : acc_x10[15:0];
		row_sum = 17'(cur_row_q) + 17'(n1);
		col_sum = 17'(cur_col_q) + 17'(n1);
		row_home = ((n1 - 16'd1) >= 16'(GRID_ROWS)) ? LAST_ROW : RW'(n1 - 16'd1);
		col_home = ((n2 - 16'd1) >= 16'(GRID_COLS)) ? LAST_COL : CW'(n2 - 16'd1);
		row_up  = (n1 >= 16'(cur_row_q)) ? '0 : RW'(16'(cur_row_q) - n1);
		col_lf  = (n1 >= 16'(cur_col_q)) ? '0 : CW'(16'(cur_col_q) - n1);
		row_dn  = (row_sum >= 17'(GRID_ROWS)) ? LAST_ROW : RW'(row_sum);
		col_rt  = (col_sum >= 17'(GRID_COLS)) ? LAST_COL : CW'(col_sum);
	end

	// Byte decode: next parser/cursor values, the one-cell write and any scroll or fill
	logic [RW-1:0] nx_row;
	logic [CW-1:0] nx_col;
	esc_state_t    nx_esc;
	csi_arg_t      nx_first, nx_second;
	logic          nx_hf, nx_hs;
	logic          acc_we;
	logic [AW-1:0] acc_waddr;
	logic [7:0]    acc_wdata;
	logic          go_scroll, go_fill;
	logic [AW-1:0] go_start, go_end;
	logic [7:0]    b;

	always_comb begin
		b         = byte_ch.byte_in;
		nx_row    = cur_row_q;
		nx_col    = cur_col_q;
		nx_esc    = esc_q;
		nx_first  = first_q;
		nx_second = second_q;
		nx_hf     = have_first_q;
		nx_hs     = have_second_q;
		acc_we    = 1'b0;
		acc_waddr = cur_addr;
		acc_wdata = b;
		go_scroll = 1'b0;
		go_fill   = 1'b0;
		go_start  = row_base;
		go_end    = row_end;
		if (!byte_ch.mode) begin
			if (esc_q == ESC_SEEN) begin
				nx_esc    = (b == CH_LBRACK) ? ESC_CSI : ESC_NORMAL;
				nx_first  = '0;
				nx_second = '0;
				nx_hf     = 1'b0;
				nx_hs     = 1'b0;
			end else if (esc_q == ESC_CSI) begin
				if (b >= CH_ZERO && b <= CH_NINE) begin
					if (have_second_q) begin
						nx_second = pushed;
					end else begin
						nx_first = pushed;
						nx_hf    = 1'b1;
					end
				end else if (b == CH_SEMI) begin
					nx_hs = 1'b1;
				end else begin
					unique case (b) inside
						CMD_ED: begin
							if (a1 == 16'd2 || a1 == 16'd3) begin
								go_fill  = 1'b1;
								go_start = '0;
								go_end   = LAST_CELL;
							end
						end
						CMD_EL: begin
							if (a1 == 16'd0) begin
								go_fill  = 1'b1;
								go_start = cur_addr;
							end else if (a1 == 16'd2) begin
								go_fill = 1'b1;
							end
						end
						CMD_HOME, CMD_HVP: begin
							nx_row = row_home;
							nx_col = col_home;
						end
						CMD_UP:    nx_row = row_up;
						CMD_DOWN:  nx_row = row_dn;
						CMD_RIGHT: nx_col = col_rt;
						CMD_LEFT:  nx_col = col_lf;
						default: ;
					endcase
					nx_esc    = ESC_NORMAL;
					nx_first  = '0;
					nx_second = '0;
					nx_hf     = 1'b0;
					nx_hs     = 1'b0;
				end
			end else begin
				if (b == CH_ESC) begin
					nx_esc = ESC_SEEN;
				end else if (b == CH_LF) begin
					nx_col = '0;
					if (cur_row_q == LAST_ROW) begin
						go_scroll = 1'b1;
					end else begin
						nx_row = cur_row_q + 1'b1;
					end
				end else if (b == CH_CR) begin
					nx_col = '0;
				end else if (b == CH_BS || b == CH_DEL) begin
					if (cur_col_q != '0) begin
						nx_col    = cur_col_q - 1'b1;
						acc_we    = 1'b1;
						acc_waddr = cur_addr - 1'b1;
						acc_wdata = CH_BLANK;
					end
				end else begin
					// Printable or unhandled control: store, then advance, wrapping at the last column
					acc_we = 1'b1;
					if (cur_col_q == LAST_COL) begin
						nx_col = '0;
						if (cur_row_q == LAST_ROW) begin
							go_scroll = 1'b1;
						end else begin
							nx_row = cur_row_q + 1'b1;
						end
					end else begin
						nx_col = cur_col_q + 1'b1;
					end
				end
			end
		end
	end

	// RAM port selection per sequencer state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_addr;
		ram_wdata = CH_BLANK;
		ram_re    = 1'b0;
		ram_raddr = rd_req_addr;
		unique case (state_q)
			ST_IDLE: begin
				ram_we    = accept && acc_we;
				ram_waddr = acc_waddr;
				ram_wdata = acc_wdata;
				ram_re    = accept && byte_ch.mode && rd_hit;
			end
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = fill_q;
			end
			ST_SCROLL, ST_DRAIN: begin
				ram_we    = cp_valid_s1;
				ram_waddr = cp_addr_s1;
				ram_wdata = ram_rdata;
				ram_re    = (state_q == ST_SCROLL);
				ram_raddr = scr_q + ROW_STEP;
			end
			default: ;
		endcase
	end

	// Sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_FILL;
			fill_q        <= '0;
			fill_end_q    <= LAST_CELL;
			fill_put_q    <= 1'b0;
			scr_q         <= '0;
			cp_valid_s1   <= 1'b0;
			cur_row_q     <= '0;
			cur_col_q     <= '0;
			esc_q         <= ESC_NORMAL;
			first_q       <= '0;
			second_q      <= '0;
			have_first_q  <= 1'b0;
			have_second_q <= 1'b0;
			cell_hit_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cur_row_q     <= nx_row;
						cur_col_q     <= nx_col;
						esc_q         <= nx_esc;
						first_q       <= nx_first;
						second_q      <= nx_second;
						have_first_q  <= nx_hf;
						have_second_q <= nx_hs;
						cell_hit_q    <= byte_ch.mode && rd_hit;
						cp_valid_s1   <= 1'b0;
						if (go_scroll) begin
							state_q <= ST_SCROLL;
							scr_q   <= '0;
						end else if (go_fill) begin
							state_q    <= ST_FILL;
							fill_q     <= go_start;
							fill_end_q <= go_end;
							fill_put_q <= 1'b1;
						end else begin
							state_q <= ST_PUT;
						end
					end
				end
				ST_FILL: begin
					if (fill_q == fill_end_q) begin
						state_q <= fill_put_q ? ST_PUT : ST_IDLE;
					end else begin
						fill_q <= fill_q + 1'b1;
					end
				end
				ST_SCROLL: begin
					// Row below is read this cycle, written one row up next cycle
					cp_valid_s1 <= 1'b1;
					scr_q       <= scr_q + 1'b1;
					if (scr_q == COPY_LAST) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					cp_valid_s1 <= 1'b0;
					state_q     <= ST_FILL;
					fill_q      <= BOTTOM_BASE;
					fill_end_q  <= LAST_CELL;
					fill_put_q  <= 1'b1;
				end
				ST_PUT: begin
					if (put_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Copy pipeline address
	always_ff @(posedge clk) begin
		if (state_q == ST_SCROLL) begin
			cp_addr_s1 <= scr_q;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (put_load) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (put_load) begin
			out_row_q  <= 5'(cur_row_q);
			out_col_q  <= 6'(cur_col_q);
			out_cell_q <= cell_hit_q ? ram_rdata : 8'd0;
			out_esc_q  <= esc_q;
		end
	end

	assign result_ch.valid          = out_valid_q;
	assign result_ch.cursor_row_out = out_row_q;
	assign result_ch.cursor_col_out = out_col_q;
	assign result_ch.cell_char      = out_cell_q;
	assign result_ch.parse_state    = out_esc_q;

	// Checks
	`ASSERT_IMPLIES(a_cursor_in_grid, clk, arst_n, 1'b1,
		(int'(cur_row_q) < GRID_ROWS) && (int'(cur_col_q) < GRID_COLS),
		"cursor left the grid")
	`ASSERT_IMPLIES(a_copy_behind_read, clk, arst_n,
		(state_q == ST_SCROLL) && cp_valid_s1, cp_addr_s1 < ram_raddr,
		"scroll write overtook its read")
	`ASSERT_NEXT(a_one_item_at_a_time, clk, arst_n, accept, !byte_ch.ready,
		"second item taken while one is in work")

endmodule
